FILE: rtl/leb128_instruction_encoder_assert.svh
// ----------------------------------------------------------------------------
// LEB128 instruction encoder assertion macros
// Shorthand for clocked concurrent checks with a report on failure.
// ----------------------------------------------------------------------------
`ifndef LEB128_INSTRUCTION_ENCODER_ASSERT_SVH
`define LEB128_INSTRUCTION_ENCODER_ASSERT_SVH

// Check that is switched off while reset is high
`define LEB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also runs through reset
`define LEB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lebenc_pkg.sv
// ----------------------------------------------------------------------------
// lebenc_pkg
// Shared types, codes and constants of the LEB128 instruction encoder.
// ----------------------------------------------------------------------------
package lebenc_pkg;

  // Field widths
  localparam int VALUE_W       = 64;
  localparam int BYTE_W        = 8;
  localparam int LEB_VALUE_BITS = 64;
  localparam int GROUP_W       = 7;

  // Immediate mode codes (code 3 means no immediate)
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_ULEB = 2'd1;
  localparam logic [1:0] REQ_SLEB = 2'd2;

  // Byte markers
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'h80;
  localparam int SIGN_BIT = 6;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE1,
    ST_PRE2,
    ST_IMM
  } state_t;

  // Byte source select
  typedef enum logic [1:0] {
    SEL_PRE1,
    SEL_PRE2,
    SEL_IMM
  } sel_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
    sel_t sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_pre;
    logic start_imm;
    logic two_prefix;
    logic has_imm;
    logic imm_done;
  } sts_t;

endpackage

FILE: rtl/leb128_instruction_encoder.sv
// Emits up to two opcode bytes of a request followed by its immediate as
// ULEB128 (low 32 bits, 1 to 5 bytes) or SLEB128 (1 to 10 bytes), one byte
// per cycle while the output is not stalled, through a single output byte
// register; the final byte of each request carries last. A request is taken
// in the idle state and then holds the block, with in_stall high, until its
// last byte is in the output register; a request that emits nothing leaves
// the block idle. The last byte may wait in the output register while the
// next request is taken.
// ----------------------------------------------------------------------------
// leb128_instruction_encoder
// Top level: controller and datapath of the LEB128 instruction encoder.
// ----------------------------------------------------------------------------
module leb128_instruction_encoder
  import lebenc_pkg::*;
#(
  parameter int VALUE_BITS = LEB_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [1:0]         prefix_count,
  input  logic [BYTE_W-1:0]  prefix_first,
  input  logic [BYTE_W-1:0]  prefix_second,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               last
);

  cmd_t cmd;
  sts_t sts;

  lebenc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lebenc_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .req_type      (req_type),
    .prefix_count  (prefix_count),
    .prefix_first  (prefix_first),
    .prefix_second (prefix_second),
    .value         (value),
    .cmd           (cmd),
    .sts           (sts),
    .out_byte      (out_byte),
    .last          (last)
  );

endmodule

FILE: rtl/lebenc_dp.sv
// ----------------------------------------------------------------------------
// lebenc_dp
// Request registers, LEB128 shift register and output byte register.
// ----------------------------------------------------------------------------
module lebenc_dp
  import lebenc_pkg::*;
#(
  parameter int VALUE_BITS = LEB_VALUE_BITS
) (
  input  logic               clk,
  input  logic [1:0]         req_type,
  input  logic [1:0]         prefix_count,
  input  logic [BYTE_W-1:0]  prefix_first,
  input  logic [BYTE_W-1:0]  prefix_second,
  input  logic [VALUE_W-1:0] value,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               last
);

  logic [VALUE_W-1:0] v;
  logic               is_signed;
  logic               has_imm;
  logic               two_prefix;
  logic [BYTE_W-1:0]  pre1;
  logic [BYTE_W-1:0]  pre2;

  logic [VALUE_W-1:0] value_ext;
  logic [VALUE_W-1:0] v_shift;
  logic               imm_done;
  logic               in_has_imm;
  logic [BYTE_W-1:0]  byte_sel;
  logic               last_sel;

  // Sign-extend the value from bit VALUE_BITS-1
  always_comb begin
    for (int i = 0; i < VALUE_W; i++) begin
      value_ext[i] = (i < VALUE_BITS) ? value[i] : value[VALUE_BITS-1];
    end
  end

  assign in_has_imm = (req_type == REQ_ULEB) || (req_type == REQ_SLEB);

  // One 7-bit group per step; arithmetic shift in signed mode
  assign v_shift = {{GROUP_W{is_signed & v[VALUE_W-1]}}, v[VALUE_W-1:GROUP_W]};

  always_comb begin
    if (is_signed) begin
      imm_done = ((v_shift == '0) && !v[SIGN_BIT]) ||
                 ((v_shift == '1) && v[SIGN_BIT]);
    end else begin
      imm_done = (v_shift == '0);
    end
  end

  // Byte and end marker for the current source
  always_comb begin
    case (cmd.sel)
      SEL_PRE1: begin
        byte_sel = pre1;
        last_sel = !two_prefix && !has_imm;
      end
      SEL_PRE2: begin
        byte_sel = pre2;
        last_sel = !has_imm;
      end
      SEL_IMM: begin
        byte_sel = {1'b0, v[GROUP_W-1:0]} | (imm_done ? '0 : CONT_MASK);
        last_sel = imm_done;
      end
      default: begin
        byte_sel = '0;
        last_sel = 1'b0;
      end
    endcase
  end

  // Request capture and immediate shifting
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pre1       <= prefix_first;
      pre2       <= prefix_second;
      two_prefix <= prefix_count[1];
      has_imm    <= in_has_imm;
      is_signed  <= (req_type == REQ_SLEB);
      if (req_type == REQ_SLEB) begin
        v <= value_ext;
      end else begin
        v <= {{(VALUE_W-32){1'b0}}, value[31:0]};
      end
    end else if (cmd.emit && (cmd.sel == SEL_IMM)) begin
      v <= v_shift;
    end
  end

  // Output byte register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= byte_sel;
      last     <= last_sel;
    end
  end

  assign sts.start_pre  = (prefix_count != 2'd0);
  assign sts.start_imm  = in_has_imm;
  assign sts.two_prefix = two_prefix;
  assign sts.has_imm    = has_imm;
  assign sts.imm_done   = imm_done;

endmodule

FILE: rtl/lebenc_ctrl.sv
// ----------------------------------------------------------------------------
// lebenc_ctrl
// Sequencer for prefix and immediate bytes, and output valid flag.
// ----------------------------------------------------------------------------
module lebenc_ctrl
  import lebenc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.start_pre) begin
            state_next = ST_PRE1;
          end else if (sts.start_imm) begin
            state_next = ST_IMM;
          end
        end
      end
      ST_PRE1: begin
        if (out_free) begin
          if (sts.two_prefix) begin
            state_next = ST_PRE2;
          end else if (sts.has_imm) begin
            state_next = ST_IMM;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PRE2: begin
        if (out_free) begin
          state_next = sts.has_imm ? ST_IMM : ST_IDLE;
        end
      end
      ST_IMM: begin
        if (out_free && sts.imm_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd.load = 1'b0;
    cmd.emit = 1'b0;
    cmd.sel  = SEL_IMM;
    case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_PRE1: begin
        cmd.emit = out_free;
        cmd.sel  = SEL_PRE1;
      end
      ST_PRE2: begin
        cmd.emit = out_free;
        cmd.sel  = SEL_PRE2;
      end
      ST_IMM:  cmd.emit = out_free;
      default: cmd.load = 1'b0;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  // Output valid follows the byte register
  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/lebenc_checker.sv
// ----------------------------------------------------------------------------
// lebenc_checker
// Port-level checks of the LEB128 instruction encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "leb128_instruction_encoder_assert.svh"

module lebenc_checker
  import lebenc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] req_type,
  input logic [1:0] prefix_count,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last
);

  logic       req_fire;
  logic       req_has_bytes;
  logic       out_wait;
  logic       out_fire;
  logic       last_out;
  logic [8:0] out_word;

  // Handshake and payload shorthands
  assign req_fire      = in_valid && !in_stall;
  assign req_has_bytes = (prefix_count != 2'd0) || (req_type inside {REQ_ULEB, REQ_SLEB});
  assign out_wait      = out_valid && out_stall;
  assign out_fire      = out_valid && !out_stall;
  assign last_out      = out_valid && last;
  assign out_word      = {out_byte, last};

  // A stalled byte stays put
  `LEB_ASSERT(a_out_hold, clk, rst, out_wait |=> out_valid && $stable(out_word), "held byte changed")

  // A request that produces bytes blocks the input next cycle
  `LEB_ASSERT(a_busy, clk, rst, req_fire && req_has_bytes |=> in_stall, "input open mid-request")

  // Input reopens only once the final byte is in the output register
  `LEB_ASSERT(a_release, clk, rst, $fell(in_stall) |-> last_out, "reopened before last byte")

  // Bytes of one request come back to back
  `LEB_ASSERT(a_no_gap, clk, rst, out_fire && !last |=> out_valid, "gap inside a byte run")

endmodule

bind leb128_instruction_encoder lebenc_checker u_lebenc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .req_type     (req_type),
  .prefix_count (prefix_count),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .last         (last)
);

FILE: tb/leb128_instruction_encoder_tb.sv
// ----------------------------------------------------------------------------
// leb128_instruction_encoder_tb
// Self-checking bench for the LEB128 instruction encoder. Opcode bytes and
// ULEB128/SLEB128 immediates are predicted per request and compared byte by
// byte, with the last flag, against the output stream. Directed corner
// requests come first, then random phases with bursty input, several receiver
// stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module leb128_instruction_encoder_tb
  import lebenc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Mode code 3 carries no immediate
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // Receiver stall patterns
  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 200000;

  // Expected output bytes, oldest first
  class leb_byte_scoreboard;
    typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
    } stream_byte_t;

    stream_byte_t pending_bytes[$];
    int           mismatches = 0;

    function void push_byte(logic [BYTE_W-1:0] data);
      stream_byte_t entry;
      entry.data = data;
      entry.last = 1'b0;
      pending_bytes.push_back(entry);
    endfunction

    // Work out the byte stream of one accepted request
    function void predict_encoding(logic [1:0] rtype, logic [1:0] pcount,
                                   logic [BYTE_W-1:0] first_op,
                                   logic [BYTE_W-1:0] second_op,
                                   logic [VALUE_W-1:0] val);
      int                  produced;
      logic [31:0]         uval;
      logic signed [63:0]  sval;
      logic [GROUP_W-1:0]  grp;
      bit                  more;
      produced = 0;
      if (pcount > 2'd2) pcount = 2'd2;
      if (pcount >= 2'd1) begin
        push_byte(first_op);
        produced++;
      end
      if (pcount >= 2'd2) begin
        push_byte(second_op);
        produced++;
      end
      // unsigned: low 32 bits, 7 bits per byte
      if (rtype == REQ_ULEB) begin
        uval = val[31:0];
        do begin
          grp = uval[GROUP_W-1:0];
          uval = uval >> GROUP_W;
          push_byte((uval != 0) ? ({1'b0, grp} | CONT_MASK) : {1'b0, grp});
          produced++;
        end while (uval != 0);
      end
      // signed: stop once the rest is pure sign and bit 6 agrees with it
      if (rtype == REQ_SLEB) begin
        sval = $signed(val << (64 - LEB_VALUE_BITS)) >>> (64 - LEB_VALUE_BITS);
        do begin
          grp = sval[GROUP_W-1:0];
          sval = sval >>> GROUP_W;
          more = !((sval == 0 && !grp[SIGN_BIT]) || (sval == '1 && grp[SIGN_BIT]));
          push_byte(more ? ({1'b0, grp} | CONT_MASK) : {1'b0, grp});
          produced++;
        end while (more);
      end
      if (produced > 0) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_byte(logic [BYTE_W-1:0] got_byte, logic got_last);
      stream_byte_t want;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h last %0b with nothing pending",
                                  got_byte, got_last));
        return;
      end
      want = pending_bytes.pop_front();
      if (got_byte !== want.data)
        report_mismatch($sformatf("out_byte %02h, want %02h", got_byte, want.data));
      if (got_last !== want.last)
        report_mismatch($sformatf("last %0b on byte %02h, want %0b",
                                  got_last, got_byte, want.last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = REQ_NONE;
  logic [1:0]         prefix_count = 2'd0;
  logic [BYTE_W-1:0]  prefix_first = '0;
  logic [BYTE_W-1:0]  prefix_second = '0;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BYTE_W-1:0]  out_byte;
  logic               last;

  int  stall_mode = STALL_NONE;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  pattern_count = 0;
  int  cycle_count = 0;

  leb_byte_scoreboard byte_board = new;

  leb128_instruction_encoder #(
    .VALUE_BITS(LEB_VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .prefix_count(prefix_count),
    .prefix_first(prefix_first),
    .prefix_second(prefix_second),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: long hold-off when asked, else the current stall pattern
  always @(negedge clk) begin
    pattern_count++;
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall = 1'b1;
    end else begin
      case (stall_mode)
        STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall = ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall = ((pattern_count % 7) < 3);
        default:        out_stall = 1'b0;
      endcase
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) byte_board.check_byte(out_byte, last);
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("leb128_instruction_encoder regression: fail");
      $finish;
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(input logic [1:0] rtype, input logic [1:0] pcount,
                              input logic [BYTE_W-1:0] first_op,
                              input logic [BYTE_W-1:0] second_op,
                              input logic [VALUE_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b1;
    req_type = rtype;
    prefix_count = pcount;
    prefix_first = first_op;
    prefix_second = second_op;
    value = val;
    do @(posedge clk); while (in_stall);
    byte_board.predict_encoding(rtype, pcount, first_op, second_op, val);
  endtask

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Stop sending until every expected byte is out, then let the block settle
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (byte_board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [1:0] random_mode();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return REQ_NONE;
    if (pick == 1) return REQ_UNKNOWN;
    if (pick < 6) return REQ_ULEB;
    return REQ_SLEB;
  endfunction

  // Values spread over all encoded lengths, with group boundaries favored
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    int                 k;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1: begin
        k = $urandom_range(1, 64);
        v = {$urandom, $urandom} & ({VALUE_W{1'b1}} >> (64 - k));
        if ($urandom_range(0, 1)) v = ~v;
      end
      2: begin
        k = $urandom_range(1, 9);
        v = (64'd1 << (7 * k - 1)) + 64'($urandom_range(0, 2)) - 64'd1;
        if ($urandom_range(0, 1)) v = ~v;
      end
      default: begin
        k = $urandom_range(1, 4);
        v = (64'd1 << (7 * k)) + 64'($urandom_range(0, 1)) - 64'd1;
        v[63:32] = $urandom;
      end
    endcase
    return v;
  endfunction

  // Random phase; empty requests do not count toward the target
  task automatic run_phase(input int target, input int stall_sel,
                           input bit with_gaps, input bit with_hold);
    int         counted;
    int         burst;
    logic [1:0] rtype;
    logic [1:0] pcount;
    counted = 0;
    stall_mode = stall_sel;
    if (with_hold) hold_req = 1'b1;
    while (counted < target) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        rtype = random_mode();
        pcount = 2'($urandom_range(0, 3));
        send_request(rtype, pcount, 8'($urandom), 8'($urandom), random_value());
        if (rtype == REQ_ULEB || rtype == REQ_SLEB || pcount != 2'd0) counted++;
      end
      if (with_gaps) pause_sender($urandom_range(0, 8));
    end
    wait_for_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners
    stall_mode = STALL_LIGHT;
    send_request(REQ_NONE, 2'd0, 8'h00, 8'h00, '0);          // empty request
    send_request(REQ_NONE, 2'd1, 8'h00, 8'hff, '1);
    send_request(REQ_NONE, 2'd2, 8'hff, 8'h00, '0);
    send_request(REQ_NONE, 2'd3, 8'h41, 8'hfc, '0);          // count saturates
    send_request(REQ_UNKNOWN, 2'd0, 8'h00, 8'h00, 64'd5);    // empty request
    send_request(REQ_UNKNOWN, 2'd2, 8'hfd, 8'h0b, 64'd5);    // immediate dropped
    send_request(REQ_ULEB, 2'd0, 8'h00, 8'h00, 64'd0);
    send_request(REQ_ULEB, 2'd0, 8'h00, 8'h00, 64'd127);
    send_request(REQ_ULEB, 2'd0, 8'h00, 8'h00, 64'd128);
    send_request(REQ_ULEB, 2'd0, 8'h00, 8'h00, 64'hffff_ffff);
    send_request(REQ_ULEB, 2'd1, 8'h20, 8'h00, 64'hdead_beef_0000_3fff);
    send_request(REQ_ULEB, 2'd2, 8'hfc, 8'h10, '1);
    send_request(REQ_SLEB, 2'd0, 8'h00, 8'h00, 64'd0);
    send_request(REQ_SLEB, 2'd0, 8'h00, 8'h00, 64'd63);
    send_request(REQ_SLEB, 2'd0, 8'h00, 8'h00, 64'd64);
    send_request(REQ_SLEB, 2'd0, 8'h00, 8'h00, -64'sd64);
    send_request(REQ_SLEB, 2'd0, 8'h00, 8'h00, -64'sd65);
    send_request(REQ_SLEB, 2'd1, 8'h41, 8'h00, '1);
    send_request(REQ_SLEB, 2'd2, 8'hff, 8'hff, 64'h7fff_ffff_ffff_ffff);
    send_request(REQ_SLEB, 2'd0, 8'h00, 8'h00, 64'h8000_0000_0000_0000);
    send_request(REQ_SLEB, 2'd1, 8'h42, 8'h00, 64'h0000_0000_ffff_ffff);
    // two immediates for one operand: second request has no prefix
    send_request(REQ_ULEB, 2'd1, 8'h28, 8'h00, 64'd300);
    send_request(REQ_SLEB, 2'd0, 8'h00, 8'h00, -64'sd300);
    wait_for_results();

    // Random phases
    run_phase(105, STALL_NONE, 1'b0, 1'b0);
    run_phase(105, STALL_LIGHT, 1'b1, 1'b0);
    run_phase(105, STALL_HEAVY, 1'b1, 1'b1);
    run_phase(105, STALL_PERIODIC, 1'b0, 1'b0);

    if (byte_board.mismatches == 0) begin
      $display("leb128_instruction_encoder regression: pass");
    end else begin
      $display("leb128_instruction_encoder regression: fail");
    end
    $finish;
  end

endmodule
